### rtl/bttec_pkg.sv
`default_nettype none

package bttec_pkg;

  localparam int unsigned LANES = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SKIP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_THRESHOLD = 2'd1;

  localparam logic [2:0] BIT_SKIP_RESET       = 3'd1;
  localparam logic [7:0] PASS_THRESHOLD_RESET = 8'd10;

  // Verdict codes.
  localparam logic [1:0] VERDICT_FAIL     = 2'd0;
  localparam logic [1:0] VERDICT_PASS     = 2'd1;
  localparam logic [1:0] VERDICT_LOW_ZERO = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sample_end;
    logic       run_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] energy_high;
    logic [31:0] energy_low;
    logic [1:0]  verdict;
  } out_item_t;

  // Which bit lanes take part for a given skip, the order of each taken lane
  // within the byte, and how many lanes are taken.
  typedef struct packed {
    logic [LANES-1:0]      mask;
    logic [LANES-1:0][2:0] ord;
    logic [3:0]            count;
  } lane_sel_t;

  // Per-lane step of the four tone counters, each -1, 0 or +1.
  typedef struct packed {
    logic [1:0] cos_hi;
    logic [1:0] sin_hi;
    logic [1:0] cos_lo;
    logic [1:0] sin_lo;
  } lane_step_t;

  // Counters of a finished sample, handed to the energy stage.
  typedef struct packed {
    logic       valid;
    logic       run;
    logic [9:0] cos_hi;
    logic [9:0] sin_hi;
    logic [8:0] cos_lo;
    logic [8:0] sin_lo;
  } sample_close_t;

  function automatic lane_sel_t lane_select(input logic [2:0] skip);
    lane_sel_t  r;
    logic [3:0] pos;
    logic [3:0] stride;
    logic [2:0] k;
    r      = '0;
    pos    = 4'd0;
    k      = 3'd0;
    stride = (skip == 3'd0) ? 4'd8 : {1'b0, skip};
    for (int i = 0; i < LANES; i++) begin
      if (pos < 4'd8) begin
        r.mask[pos[2:0]] = 1'b1;
        r.ord[pos[2:0]]  = k;
        r.count          = r.count + 4'd1;
        pos              = pos + stride;
        k                = k + 3'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/bttec_lane.sv
`default_nettype none

module bttec_lane (
  input  wire logic              bit_in,
  input  wire logic              taken,
  input  wire logic [2:0]        phase,
  output bttec_pkg::lane_step_t  step
);
  import bttec_pkg::*;

  localparam logic [1:0] PLUS  = 2'b01;
  localparam logic [1:0] MINUS = 2'b11;

  always_comb begin
    step = '0;
    if (bit_in && taken) begin
      case (phase)
        3'd0: begin
          step.cos_hi = PLUS;
          step.cos_lo = PLUS;
        end
        3'd1: step.sin_hi = PLUS;
        3'd2: begin
          step.cos_hi = MINUS;
          step.sin_lo = PLUS;
        end
        3'd3: step.sin_hi = MINUS;
        3'd4: begin
          step.cos_hi = PLUS;
          step.cos_lo = MINUS;
        end
        3'd5: step.sin_hi = PLUS;
        3'd6: begin
          step.cos_hi = MINUS;
          step.sin_lo = MINUS;
        end
        default: step.sin_hi = MINUS;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/bttec_merge.sv
`default_nettype none

module bttec_merge (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     take,
  input  wire bttec_pkg::in_item_t      item,
  input  wire logic [2:0]               bit_skip,
  output bttec_pkg::sample_close_t      close_out
);
  import bttec_pkg::*;

  lane_sel_t                sel;
  lane_step_t [LANES-1:0]   steps;
  logic [4:0]               sum_ch, sum_sh, sum_cl, sum_sl;
  logic [2:0]               phase_r, phase_nxt;
  logic [9:0]               cos_hi_r, sin_hi_r, cos_hi_nxt, sin_hi_nxt;
  logic [8:0]               cos_lo_r, sin_lo_r, cos_lo_nxt, sin_lo_nxt;
  sample_close_t            close_r;
  logic                     closing;

  assign sel = lane_select(bit_skip);

  // Bit lane i looks at byte bit 7-i, the MSB being position 0.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [2:0] lane_phase;
    assign lane_phase = phase_r + sel.ord[i];
    bttec_lane u_lane (
      .bit_in (item.data_byte[LANES-1-i]),
      .taken  (sel.mask[i]),
      .phase  (lane_phase),
      .step   (steps[i])
    );
  end

  always_comb begin
    sum_ch = '0;
    sum_sh = '0;
    sum_cl = '0;
    sum_sl = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_ch = sum_ch + {{3{steps[i].cos_hi[1]}}, steps[i].cos_hi};
      sum_sh = sum_sh + {{3{steps[i].sin_hi[1]}}, steps[i].sin_hi};
      sum_cl = sum_cl + {{3{steps[i].cos_lo[1]}}, steps[i].cos_lo};
      sum_sl = sum_sl + {{3{steps[i].sin_lo[1]}}, steps[i].sin_lo};
    end
  end

  assign cos_hi_nxt = cos_hi_r + {{5{sum_ch[4]}}, sum_ch};
  assign sin_hi_nxt = sin_hi_r + {{5{sum_sh[4]}}, sum_sh};
  assign cos_lo_nxt = cos_lo_r + {{4{sum_cl[4]}}, sum_cl};
  assign sin_lo_nxt = sin_lo_r + {{4{sum_sl[4]}}, sum_sl};
  assign phase_nxt  = phase_r + sel.count[2:0];
  assign closing    = item.sample_end || item.run_end;

  // The counter snapshot is taken on every edge; only the flags need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      cos_hi_r <= '0;
      sin_hi_r <= '0;
      cos_lo_r <= '0;
      sin_lo_r <= '0;
      close_r.valid <= 1'b0;
      close_r.run   <= 1'b0;
    end else begin
      close_r.valid <= take && closing;
      close_r.run   <= take && item.run_end;
      if (take) begin
        if (closing) begin
          phase_r  <= '0;
          cos_hi_r <= '0;
          sin_hi_r <= '0;
          cos_lo_r <= '0;
          sin_lo_r <= '0;
        end else begin
          phase_r  <= phase_nxt;
          cos_hi_r <= cos_hi_nxt;
          sin_hi_r <= sin_hi_nxt;
          cos_lo_r <= cos_lo_nxt;
          sin_lo_r <= sin_lo_nxt;
        end
      end
    end
    close_r.cos_hi <= cos_hi_nxt;
    close_r.sin_hi <= sin_hi_nxt;
    close_r.cos_lo <= cos_lo_nxt;
    close_r.sin_lo <= sin_lo_nxt;
  end

  assign close_out = close_r;

endmodule

`default_nettype wire

### rtl/bttec_energy.sv
`default_nettype none

module bttec_energy (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bttec_pkg::sample_close_t close_in,
  input  wire logic [7:0]               pass_threshold,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output bttec_pkg::out_item_t          out_data
);
  import bttec_pkg::*;

  logic               sq_v_r, sq_run_r;
  logic [19:0]        sq_ch_r, sq_sh_r;
  logic [17:0]        sq_cl_r, sq_sl_r;
  logic [31:0]        tot_hi_r, tot_lo_r, tot_hi_nxt, tot_lo_nxt;
  logic               fin_v_r;
  logic [31:0]        fin_hi_r, fin_lo_r;
  logic               prod_v_r;
  logic [31:0]        prod_hi_r, prod_lo_r;
  logic [40:0]        prod_r;
  logic [8:0]         limit;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;
  logic signed [9:0]  ch_s, sh_s;
  logic signed [8:0]  cl_s, sl_s;

  assign ch_s = $signed(close_in.cos_hi);
  assign sh_s = $signed(close_in.sin_hi);
  assign cl_s = $signed(close_in.cos_lo);
  assign sl_s = $signed(close_in.sin_lo);

  always_ff @(posedge clk) begin
    sq_ch_r <= ch_s * ch_s;
    sq_sh_r <= sh_s * sh_s;
    sq_cl_r <= cl_s * cl_s;
    sq_sl_r <= sl_s * sl_s;
  end

  assign tot_hi_nxt = tot_hi_r + {12'd0, sq_ch_r} + {12'd0, sq_sh_r};
  assign tot_lo_nxt = tot_lo_r + {14'd0, sq_cl_r} + {14'd0, sq_sl_r};

  // floor(hi / lo) > T is the same as hi >= (T + 1) * lo.
  assign limit = {1'b0, pass_threshold} + 9'd1;

  always_ff @(posedge clk) begin
    if (sq_v_r && sq_run_r) begin
      fin_hi_r <= tot_hi_nxt;
      fin_lo_r <= tot_lo_nxt;
    end
    prod_r    <= {9'd0, fin_lo_r} * {32'd0, limit};
    prod_hi_r <= fin_hi_r;
    prod_lo_r <= fin_lo_r;
  end

  always_comb begin
    out_data_nxt.energy_high = prod_hi_r;
    out_data_nxt.energy_low  = prod_lo_r;
    if (prod_lo_r == 32'd0) begin
      out_data_nxt.verdict = VERDICT_LOW_ZERO;
    end else if ({9'd0, prod_hi_r} >= prod_r) begin
      out_data_nxt.verdict = VERDICT_PASS;
    end else begin
      out_data_nxt.verdict = VERDICT_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r      <= 1'b0;
      sq_run_r    <= 1'b0;
      tot_hi_r    <= '0;
      tot_lo_r    <= '0;
      fin_v_r     <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_v_r   <= close_in.valid;
      sq_run_r <= close_in.run;
      fin_v_r  <= sq_v_r && sq_run_r;
      prod_v_r <= fin_v_r;
      if (sq_v_r) begin
        if (sq_run_r) begin
          tot_hi_r <= '0;
          tot_lo_r <= '0;
        end else begin
          tot_hi_r <= tot_hi_nxt;
          tot_lo_r <= tot_lo_nxt;
        end
      end
      if (prod_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/bitstream_two_tone_energy_check.sv
// Two-tone bit energy check.
// Input channel (in_valid, in_stall, in_data): one raw byte per transfer with
// its sample_end and run_end marks. The eight bit lanes handle every chosen
// bit of a byte in the same cycle, so a byte can be taken on every clock.
// After the transfer of a byte that carries run_end, in_stall stays high
// until that run's result has been taken; that is the only time the block
// holds off its input.
// Result channel (out_valid, out_stall, out_data): one transfer per run with
// both energy totals and the verdict. After the run_end byte, the result is
// registered in turn by the counter update, squaring, energy totals, the ratio
// multiply, and the output register.
// While out_stall is high the result is held unchanged in the output register.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// writes are meant only while the block is idle.
// Synchronous reset (rst_n low) clears the tone counters, the energy totals
// and all valid flags, and loads bit_skip = 1 and pass_threshold = 10.
`default_nettype none

module bitstream_two_tone_energy_check (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire bttec_pkg::in_item_t                in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bttec_pkg::out_item_t                    out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bttec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bttec_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bttec_pkg::*;

  logic [2:0]    skip_r;
  logic [7:0]    threshold_r;
  logic          busy_r;
  logic          in_take;
  logic          out_take;
  sample_close_t close_w;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // A run in flight blocks further bytes until its result transfer is done.
  assign in_stall = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= BIT_SKIP_RESET;
      threshold_r <= PASS_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_SKIP:       skip_r      <= cfg_data[2:0];
        CFG_PASS_THRESHOLD: threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_take && in_data.run_end) begin
      busy_r <= 1'b1;
    end else if (out_take) begin
      busy_r <= 1'b0;
    end
  end

  bttec_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .item      (in_data),
    .bit_skip  (skip_r),
    .close_out (close_w)
  );

  bttec_energy u_energy (
    .clk            (clk),
    .rst_n          (rst_n),
    .close_in       (close_w),
    .pass_threshold (threshold_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

`ifndef SYNTHESIS
  a_out_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result shown with no run in flight");

  a_run_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_data.run_end) |=> in_stall)
    else $error("input not held off after run end");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |=> !out_valid)
    else $error("second result after a run");

  a_no_close_while_idle_bit: assert property (@(posedge clk) disable iff (!rst_n)
    close_w.run |-> (close_w.valid && busy_r))
    else $error("run close without an accepted run end");
`endif

endmodule

`default_nettype wire
